### hdl/quaternion_vector_rotate_top_defines.svh
// Assertion macros shared by the quaternion rotation RTL.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define QVR_ASSERT_IMP(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("qvr assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define QVR_ASSERT_NXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("qvr assertion failed");

`endif

### hdl/qvr_pkg.sv
// Shared constants, Hamilton product term tables and width helpers.
`default_nettype none

package qvr_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int FRAC_BITS       = 14;

	// Hamilton product p*q: component c is the sum of four terms
	// (+/-) p[HAM_P] * q[HAM_Q], term index 4*c+k.
	localparam logic [1:0] HAM_P [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd1, 2'd0, 2'd2, 2'd3,
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd1, 2'd2, 2'd3
	};
	localparam logic [1:0] HAM_Q [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd1, 2'd3, 2'd2,
		2'd2, 2'd3, 2'd0, 2'd1,
		2'd3, 2'd2, 2'd1, 2'd0
	};
	// bit 4*c+k set: term is subtracted
	localparam logic [15:0] HAM_NEG = 16'b0100_0010_1000_1110;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Accumulator width for four products of p_w bits plus the rounding bias.
	function automatic int sum_w(input int p_w, input int f);
		return imax(p_w + 3, f + 2);
	endfunction

	// Width of a rounded, shifted sum.
	function automatic int rnd_w(input int p_w, input int f);
		return sum_w(p_w, f) - f;
	endfunction

	// Term signs; with a conjugated right operand its vector parts flip sign.
	function automatic logic [15:0] ham_neg(input logic conj_b);
		logic [15:0] n;
		n = HAM_NEG;
		for (int g = 0; g < 16; g++) begin
			if (conj_b && (HAM_Q[g] != 2'd0)) begin
				n[g] = ~n[g];
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### hdl/quaternion_vector_rotate_top.sv
// Quaternion vector rotation r*v*conj(r): two pipelined Hamilton products and saturation.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | rot_w rot_x rot_y rot_z vec_w vec_x vec_y vec_z
//  out     | out_valid/out_stall| out_w out_x out_y out_z saturated
//
// One transfer per cycle in each direction while no stall holds the flow; three
// stages per Hamilton product (partial products, recombine, sum and round) plus the
// saturating output register.
// Reset clears only the valid bits; payload registers are not reset.
// A stall at the output fills empty stages first; in_stall rises only when
// every stage holds an item.
`default_nettype none
`include "quaternion_vector_rotate_top_defines.svh"

module quaternion_vector_rotate_top #(
	parameter int COMPONENT_WIDTH = qvr_pkg::COMPONENT_WIDTH,
	parameter int FRAC_BITS       = qvr_pkg::FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COMPONENT_WIDTH-1:0] rot_w,
	input  logic signed [COMPONENT_WIDTH-1:0] rot_x,
	input  logic signed [COMPONENT_WIDTH-1:0] rot_y,
	input  logic signed [COMPONENT_WIDTH-1:0] rot_z,
	input  logic signed [COMPONENT_WIDTH-1:0] vec_w,
	input  logic signed [COMPONENT_WIDTH-1:0] vec_x,
	input  logic signed [COMPONENT_WIDTH-1:0] vec_y,
	input  logic signed [COMPONENT_WIDTH-1:0] vec_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [COMPONENT_WIDTH-1:0] out_w,
	output logic signed [COMPONENT_WIDTH-1:0] out_x,
	output logic signed [COMPONENT_WIDTH-1:0] out_y,
	output logic signed [COMPONENT_WIDTH-1:0] out_z,
	output logic saturated
);

	localparam int W    = COMPONENT_WIDTH;
	localparam int R1_W = qvr_pkg::rnd_w(2 * W, FRAC_BITS);
	localparam int R2_W = qvr_pkg::rnd_w(R1_W + W, FRAC_BITS);
	localparam int UX_W = qvr_pkg::imax(R2_W, W + 1);
	localparam logic signed [W-1:0] OUT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] OUT_MIN = {1'b1, {(W-1){1'b0}}};

	logic signed [W-1:0]    rot [4];
	logic signed [W-1:0]    vec [4];
	logic signed [R1_W-1:0] t   [4];
	logic signed [R2_W-1:0] u   [4];
	logic                   h1_in_ready, t_valid, t_ready;
	logic                   u_valid, u_ready;
	logic signed [W-1:0]    res    [4];
	logic                   sat_any;
	logic signed [W-1:0]    res_s7 [4];
	logic                   sat_s7, v_s7;
	logic signed [W-1:0]    rot_s1 [4];
	logic signed [W-1:0]    rot_s2 [4];
	logic signed [W-1:0]    rot_s3 [4];
	logic                   rv_s1, rv_s2, rv_s3;
	logic                   rrdy_s1, rrdy_s2, rrdy_s3;
	logic                   out_at_lim;

	assign rot = '{rot_w, rot_x, rot_y, rot_z};
	assign vec = '{vec_w, vec_x, vec_y, vec_z};

	// t = r * v, rounded and kept at R1_W bits, not saturated
	qvr_hamilton #(
		.A_W   (W),
		.B_W   (W),
		.FRAC  (FRAC_BITS),
		.CONJ_B(1'b0)
	) u_ham_rv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (h1_in_ready),
		.a        (rot),
		.b        (vec),
		.out_valid(t_valid),
		.out_ready(t_ready),
		.r        (t)
	);

	// Rotation delay line: same stage chain as the first unit, so each
	// rotation reaches the second unit together with its t
	assign rrdy_s3 = !rv_s3 || t_ready;
	assign rrdy_s2 = !rv_s2 || rrdy_s3;
	assign rrdy_s1 = !rv_s1 || rrdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
			rv_s3 <= 1'b0;
		end else begin
			if (rrdy_s1) rv_s1 <= in_valid;
			if (rrdy_s2) rv_s2 <= rv_s1;
			if (rrdy_s3) rv_s3 <= rv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rrdy_s1) begin
			rot_s1 <= rot;
		end
		if (rrdy_s2) begin
			rot_s2 <= rot_s1;
		end
		if (rrdy_s3) begin
			rot_s3 <= rot_s2;
		end
	end

	// u = t * conj(r)
	qvr_hamilton #(
		.A_W   (R1_W),
		.B_W   (W),
		.FRAC  (FRAC_BITS),
		.CONJ_B(1'b1)
	) u_ham_tc (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (t_valid),
		.in_ready (t_ready),
		.a        (t),
		.b        (rot_s3),
		.out_valid(u_valid),
		.out_ready(u_ready),
		.r        (u)
	);

	// Saturate each component to W signed bits
	always_comb begin
		logic signed [UX_W-1:0] ux;
		sat_any = 1'b0;
		for (int i = 0; i < 4; i++) begin
			ux = UX_W'(u[i]);
			if ((&ux[UX_W-1:W-1]) || !(|ux[UX_W-1:W-1])) begin
				res[i] = ux[W-1:0];
			end else begin
				res[i]  = ux[UX_W-1] ? OUT_MIN : OUT_MAX;
				sat_any = 1'b1;
			end
		end
	end

	// Output register
	assign u_ready  = !v_s7 || !out_stall;
	assign in_stall = !h1_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (u_ready) begin
			v_s7 <= u_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (u_ready) begin
			res_s7 <= res;
			sat_s7 <= sat_any;
		end
	end

	assign out_valid = v_s7;
	assign out_w     = res_s7[0];
	assign out_x     = res_s7[1];
	assign out_y     = res_s7[2];
	assign out_z     = res_s7[3];
	assign saturated = sat_s7;

	// some component sits at a limit
	assign out_at_lim = (out_w == OUT_MAX) || (out_w == OUT_MIN) ||
		(out_x == OUT_MAX) || (out_x == OUT_MIN) ||
		(out_y == OUT_MAX) || (out_y == OUT_MIN) ||
		(out_z == OUT_MAX) || (out_z == OUT_MIN);

	`QVR_ASSERT_IMP(a_sat_at_limit, clk, arst_n, out_valid && saturated, out_at_lim)
	`QVR_ASSERT_NXT(a_result_lands, clk, arst_n, u_valid && u_ready, out_valid)
	`QVR_ASSERT_IMP(a_rot_aligned, clk, arst_n, 1'b1, (rv_s3 == t_valid) && (rrdy_s1 == h1_in_ready))

endmodule

`default_nettype wire

### hdl/qvr_hamilton.sv
// Three-stage pipelined Hamilton product with round-half-up scaling.
`default_nettype none
`include "quaternion_vector_rotate_top_defines.svh"

module qvr_hamilton #(
	parameter int A_W    = qvr_pkg::COMPONENT_WIDTH,
	parameter int B_W    = qvr_pkg::COMPONENT_WIDTH,
	parameter int FRAC   = qvr_pkg::FRAC_BITS,
	parameter bit CONJ_B = 1'b0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [A_W-1:0] a [4],
	input  logic signed [B_W-1:0] b [4],
	output logic out_valid,
	input  logic out_ready,
	output logic signed [qvr_pkg::rnd_w(A_W+B_W, FRAC)-1:0] r [4]
);

	// Left operand is split into an unsigned low slice of B_W bits and a
	// signed high slice, so each multiplier stays near B_W x B_W.
	localparam int LO_W = B_W;
	localparam int AX_W = (A_W > LO_W) ? A_W : LO_W + 1;
	localparam int HI_W = AX_W - LO_W;
	localparam int PL_W = LO_W + 1 + B_W;
	localparam int PH_W = HI_W + B_W;
	localparam int P_W  = A_W + B_W;
	localparam int S_W  = qvr_pkg::sum_w(P_W, FRAC);
	localparam int R_W  = S_W - FRAC;
	localparam logic [15:0] NEG = qvr_pkg::ham_neg(CONJ_B);
	localparam logic signed [S_W-1:0] RND = S_W'(1) <<< (FRAC - 1);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [PL_W-1:0] pp_lo     [16];
	logic signed [PH_W-1:0] pp_hi     [16];
	logic signed [PL_W-1:0] pp_lo_s1  [16];
	logic signed [PH_W-1:0] pp_hi_s1  [16];
	logic signed [P_W-1:0]  prod      [16];
	logic signed [P_W-1:0]  prod_s2   [16];
	logic signed [S_W-1:0]  acc       [4];
	logic signed [R_W-1:0]  rnd       [4];
	logic signed [R_W-1:0]  r_s3      [4];

	// Stage ready chain: a stage takes new data when empty or draining
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Stage 1: partial products
	for (genvar g = 0; g < 16; g++) begin : g_pp
		logic signed [AX_W-1:0] ax;
		assign ax       = AX_W'(a[qvr_pkg::HAM_P[g]]);
		assign pp_lo[g] = $signed({1'b0, ax[LO_W-1:0]}) * b[qvr_pkg::HAM_Q[g]];
		assign pp_hi[g] = $signed(ax[AX_W-1:LO_W]) * b[qvr_pkg::HAM_Q[g]];
	end

	// Stage 2: recombine partial products into full products
	for (genvar g = 0; g < 16; g++) begin : g_prod
		assign prod[g] = (P_W'(pp_hi_s1[g]) <<< LO_W) + P_W'(pp_lo_s1[g]);
	end

	// Stage 3: signed sum of four terms, bias, arithmetic shift
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			acc[c] = RND;
			for (int k = 0; k < 4; k++) begin
				if (NEG[4*c+k]) begin
					acc[c] = acc[c] - S_W'(prod_s2[4*c+k]);
				end else begin
					acc[c] = acc[c] + S_W'(prod_s2[4*c+k]);
				end
			end
			rnd[c] = R_W'(acc[c] >>> FRAC);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			pp_lo_s1 <= pp_lo;
			pp_hi_s1 <= pp_hi;
		end
		if (rdy_s2) begin
			prod_s2 <= prod;
		end
		if (rdy_s3) begin
			r_s3 <= rnd;
		end
	end

	assign out_valid = v_s3;
	assign r         = r_s3;

	`QVR_ASSERT_IMP(a_stall_only_full, clk, arst_n, !in_ready, v_s1 && v_s2 && v_s3 && !out_ready)
	`QVR_ASSERT_NXT(a_transfer_enters, clk, arst_n, in_valid && in_ready, v_s1)
	`QVR_ASSERT_NXT(a_result_holds, clk, arst_n, v_s3 && !out_ready, v_s3 && $stable(r_s3[0]) && $stable(r_s3[3]))

endmodule

`default_nettype wire
